@@ rtl/core/wavp_pkg.sv @@
package wavp_pkg;

  // Parse phases, in file order
  typedef enum logic [3:0] {
    PH_RIFF    = 4'd0,
    PH_FSIZE   = 4'd1,
    PH_WAVE    = 4'd2,
    PH_FMT     = 4'd3,
    PH_LEN1    = 4'd4,
    PH_FORMAT  = 4'd5,
    PH_NCH     = 4'd6,
    PH_RATE    = 4'd7,
    PH_BRATE   = 4'd8,
    PH_ALIGN   = 4'd9,
    PH_BPS     = 4'd10,
    PH_DATA    = 4'd11,
    PH_DSIZE   = 4'd12,
    PH_SAMPLES = 4'd13,
    PH_DONE    = 4'd14
  } phase_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Tags, first character in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [15:0] BYTE_SAMPLE_BITS = 16'd8;
  localparam logic [31:0] FMT_BASE_LEN     = 32'd16;

  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample_value;
    logic [15:0]        channel;
    logic [31:0]        riff_size;
    logic [31:0]        fmt_length;
    logic [15:0]        audio_format;
    logic [15:0]        chan_count;
    logic [31:0]        rate_hz;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_len;
  } wavp_result_t;

endpackage

@@ rtl/core/wavp_if.sv @@
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;

  modport source (output valid, output data_byte, output start_of_stream, input ready);
  modport sink (input valid, input data_byte, input start_of_stream, output ready);
endinterface

interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample_value;
  logic [15:0]        channel;
  logic [31:0]        riff_size;
  logic [31:0]        fmt_length;
  logic [15:0]        audio_format;
  logic [15:0]        chan_count;
  logic [31:0]        rate_hz;
  logic [31:0]        byte_rate;
  logic [15:0]        block_align;
  logic [15:0]        bits_per_sample;
  logic [31:0]        data_len;

  modport source (
    output valid, output kind, output sample_value, output channel,
    output riff_size, output fmt_length, output audio_format, output chan_count,
    output rate_hz, output byte_rate, output block_align, output bits_per_sample,
    output data_len, input ready
  );
  modport sink (
    input valid, input kind, input sample_value, input channel,
    input riff_size, input fmt_length, input audio_format, input chan_count,
    input rate_hz, input byte_rate, input block_align, input bits_per_sample,
    input data_len, output ready
  );
endinterface

@@ rtl/core/wavp_out_buf.sv @@
module wavp_out_buf
  import wavp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  wavp_result_t item,
  output logic         space,
  wavp_out_if.source   result
);

  localparam int PtrW = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
  localparam int CntW = $clog2(OBUF_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(OBUF_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(OBUF_DEPTH);

  wavp_result_t entry [OBUF_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            pop;
  wavp_result_t    head;

  assign space = (count != FullCnt);
  assign pop   = result.valid && result.ready;
  assign head  = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item;
    end
  end

  assign result.valid           = (count != '0);
  assign result.kind            = head.kind;
  assign result.sample_value    = head.sample_value;
  assign result.channel         = head.channel;
  assign result.riff_size       = head.riff_size;
  assign result.fmt_length      = head.fmt_length;
  assign result.audio_format    = head.audio_format;
  assign result.chan_count      = head.chan_count;
  assign result.rate_hz         = head.rate_hz;
  assign result.byte_rate       = head.byte_rate;
  assign result.block_align     = head.block_align;
  assign result.bits_per_sample = head.bits_per_sample;
  assign result.data_len        = head.data_len;

endmodule

@@ rtl/core/wav_header_and_sample_parser.sv @@
// Channel   Dir   Payload                                   Item
// stream    in    data_byte[7:0], start_of_stream           one byte of the WAV file
// result    out   kind, sample_value, channel, header set   one header or one sample
//
// One byte is taken every cycle when nothing stalls. A byte accepted on stream is held in
// the input register and parsed out of it once the output buffer has room; its result (if any)
// is then written into a two-entry output buffer and shows on result from then on.
// rst (synchronous) returns to waiting for the RIFF tag; start_of_stream does the
// same for its own byte, which is then parsed as the first tag byte.
// stream.ready drops only while the output buffer is full and the input register holds a byte.
module wav_header_and_sample_parser
  import wavp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  wavp_in_if.sink    stream,
  wavp_out_if.source result
);

  // Input register
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_sos;
  logic       stg_adv;
  logic       buf_space;

  // Parser state
  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  byte_idx;
  logic [2:0]  byte_idx_next;
  logic        mismatch;
  logic        mismatch_next;
  logic [31:0] assembly;
  logic [31:0] assembly_next;
  logic [31:0] skip;
  logic [31:0] skip_next;

  // Header fields
  logic [31:0] riff_size;
  logic [31:0] fmt_length;
  logic [15:0] audio_format;
  logic [15:0] chan_count;
  logic [31:0] rate_hz;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;

  // Sample stage
  logic [31:0] bytes_left;
  logic [31:0] bytes_left_next;
  logic [16:0] frame_len;
  logic [16:0] frame_len_next;
  logic [16:0] frame_pos;
  logic [16:0] frame_pos_next;
  logic [15:0] chan;
  logic [15:0] chan_next;
  logic [7:0]  low_hold;
  logic [7:0]  low_hold_next;

  // Decode of the current byte
  phase_t      cur_phase;
  logic [2:0]  cur_idx;
  logic        cur_mm;
  logic [31:0] cur_asm;
  logic [31:0] cur_skip;
  logic        skipping;
  logic [7:0]  tag_char;
  logic        tag_hit;
  logic        tag_acc_mm;
  phase_t      tag_follow;
  phase_t      field_follow;
  logic        field_len4;
  logic        field_last;
  logic [31:0] asm_acc;
  logic        byte_samples;
  logic        frame_stop;
  logic [16:0] frame_pos_inc;
  logic        chan_wrap;
  logic        emit;
  wavp_result_t res;

  // Input register: advance when the buffer has room for whatever this byte makes
  assign stg_adv      = stg_valid && buf_space;
  assign stream.ready = !stg_valid || buf_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      stg_valid <= 1'b1;
    end else if (stg_adv) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      stg_byte <= stream.data_byte;
      stg_sos  <= stream.start_of_stream;
    end
  end

  // start_of_stream restarts the control state before its byte is parsed
  assign cur_phase = stg_sos ? PH_RIFF : phase;
  assign cur_idx   = stg_sos ? 3'd0 : byte_idx;
  assign cur_mm    = stg_sos ? 1'b0 : mismatch;
  assign cur_asm   = stg_sos ? 32'd0 : assembly;
  assign cur_skip  = stg_sos ? 32'd0 : skip;
  assign skipping  = (cur_skip != 32'd0);

  // Per-phase decode: tag text, successor phases, field length
  always_comb begin
    tag_char     = TAG_DATA[31:24];
    tag_follow   = PH_DSIZE;
    field_follow = PH_WAVE;
    field_len4   = 1'b1;
    unique case (cur_phase) inside
      PH_RIFF: begin
        tag_follow = PH_FSIZE;
        case (cur_idx[1:0])
          2'd0:    tag_char = TAG_RIFF[31:24];
          2'd1:    tag_char = TAG_RIFF[23:16];
          2'd2:    tag_char = TAG_RIFF[15:8];
          default: tag_char = TAG_RIFF[7:0];
        endcase
      end
      PH_WAVE: begin
        tag_follow = PH_FMT;
        case (cur_idx[1:0])
          2'd0:    tag_char = TAG_WAVE[31:24];
          2'd1:    tag_char = TAG_WAVE[23:16];
          2'd2:    tag_char = TAG_WAVE[15:8];
          default: tag_char = TAG_WAVE[7:0];
        endcase
      end
      PH_FMT: begin
        tag_follow = PH_LEN1;
        case (cur_idx[1:0])
          2'd0:    tag_char = TAG_FMT[31:24];
          2'd1:    tag_char = TAG_FMT[23:16];
          2'd2:    tag_char = TAG_FMT[15:8];
          default: tag_char = TAG_FMT[7:0];
        endcase
      end
      PH_DATA: begin
        tag_follow = PH_DSIZE;
        case (cur_idx[1:0])
          2'd0:    tag_char = TAG_DATA[31:24];
          2'd1:    tag_char = TAG_DATA[23:16];
          2'd2:    tag_char = TAG_DATA[15:8];
          default: tag_char = TAG_DATA[7:0];
        endcase
      end
      PH_FSIZE:  field_follow = PH_WAVE;
      PH_LEN1:   field_follow = PH_FORMAT;
      PH_FORMAT: begin
        field_follow = PH_NCH;
        field_len4   = 1'b0;
      end
      PH_NCH: begin
        field_follow = PH_RATE;
        field_len4   = 1'b0;
      end
      PH_RATE:   field_follow = PH_BRATE;
      PH_BRATE:  field_follow = PH_ALIGN;
      PH_ALIGN: begin
        field_follow = PH_BPS;
        field_len4   = 1'b0;
      end
      PH_BPS: begin
        field_follow = PH_DATA;
        field_len4   = 1'b0;
      end
      PH_DSIZE:  field_follow = PH_SAMPLES;
      default: begin
      end
    endcase
  end

  assign tag_hit    = (stg_byte == tag_char);
  assign tag_acc_mm = cur_mm || !tag_hit;
  // Both field bytes and skip-length bytes land at the low two index bits
  assign asm_acc    = cur_asm | (32'(stg_byte) << {cur_idx[1:0], 3'b000});
  assign field_last = field_len4 ? (cur_idx[1:0] == 2'd3) : (cur_idx[1:0] != 2'd0);

  // Sample framing: a frame starts only if it fits whole in what is left
  assign byte_samples  = (bits_per_sample == BYTE_SAMPLE_BITS);
  assign frame_stop    = (frame_pos == 17'd0) &&
                         ((frame_len == 17'd0) || (bytes_left < 32'(frame_len)));
  assign frame_pos_inc = frame_pos + 17'd1;
  assign chan_wrap     = ({1'b0, chan} + 17'd1) >= {1'b0, chan_count};

  // Next phase
  always_comb begin
    phase_next = cur_phase;
    if (!skipping) begin
      unique case (cur_phase) inside
        PH_RIFF, PH_WAVE, PH_FMT, PH_DATA: begin
          if (cur_idx == 3'd3 && !tag_acc_mm) begin
            phase_next = tag_follow;
          end
        end
        PH_FSIZE, PH_LEN1, PH_FORMAT, PH_NCH, PH_RATE, PH_BRATE, PH_ALIGN, PH_BPS,
        PH_DSIZE: begin
          if (field_last) begin
            phase_next = field_follow;
          end
        end
        PH_SAMPLES: begin
          if (frame_stop) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath next values and result
  always_comb begin
    byte_idx_next   = cur_idx;
    mismatch_next   = cur_mm;
    assembly_next   = cur_asm;
    skip_next       = cur_skip;
    bytes_left_next = bytes_left;
    frame_len_next  = frame_len;
    frame_pos_next  = frame_pos;
    chan_next       = chan;
    low_hold_next   = low_hold;
    emit            = 1'b0;
    res             = '0;
    if (skipping) begin
      // drop the byte, count the skip down
      skip_next = cur_skip - 32'd1;
    end else begin
      unique case (cur_phase) inside
        PH_RIFF, PH_WAVE, PH_FMT, PH_DATA: begin
          if (!cur_idx[2]) begin
            mismatch_next = tag_acc_mm;
            if (cur_idx == 3'd3) begin
              if (tag_acc_mm) begin
                byte_idx_next = 3'd4;
                assembly_next = 32'd0;
              end else begin
                byte_idx_next = 3'd0;
              end
            end else begin
              byte_idx_next = cur_idx + 3'd1;
            end
          end else begin
            // chunk length of an unwanted chunk, then skip its body
            if (cur_idx == 3'd7) begin
              skip_next     = asm_acc;
              assembly_next = 32'd0;
              byte_idx_next = 3'd0;
              mismatch_next = 1'b0;
            end else begin
              assembly_next = asm_acc;
              byte_idx_next = cur_idx + 3'd1;
            end
          end
        end
        PH_FSIZE, PH_LEN1, PH_FORMAT, PH_NCH, PH_RATE, PH_BRATE, PH_ALIGN, PH_BPS,
        PH_DSIZE: begin
          if (field_last) begin
            assembly_next = 32'd0;
            byte_idx_next = 3'd0;
            if (cur_phase == PH_BPS && fmt_length > FMT_BASE_LEN) begin
              skip_next = fmt_length - FMT_BASE_LEN;
            end
            if (cur_phase == PH_DSIZE) begin
              bytes_left_next      = asm_acc;
              frame_len_next       = byte_samples ? {1'b0, chan_count}
                                                  : {chan_count, 1'b0};
              frame_pos_next       = 17'd0;
              chan_next            = 16'd0;
              emit                 = 1'b1;
              res.kind             = KIND_HEADER;
              res.riff_size        = riff_size;
              res.fmt_length       = fmt_length;
              res.audio_format     = audio_format;
              res.chan_count       = chan_count;
              res.rate_hz          = rate_hz;
              res.byte_rate        = byte_rate;
              res.block_align      = block_align;
              res.bits_per_sample  = bits_per_sample;
              res.data_len         = asm_acc;
            end
          end else begin
            assembly_next = asm_acc;
            byte_idx_next = cur_idx + 3'd1;
          end
        end
        PH_SAMPLES: begin
          if (!frame_stop) begin
            bytes_left_next = bytes_left - 32'd1;
            frame_pos_next  = (frame_pos_inc == frame_len) ? 17'd0 : frame_pos_inc;
            if (byte_samples || cur_idx[0]) begin
              emit             = 1'b1;
              res.kind         = KIND_SAMPLE;
              res.sample_value = byte_samples ? {stg_byte, 8'h00} : {stg_byte, low_hold};
              res.channel      = chan;
              chan_next        = chan_wrap ? 16'd0 : chan + 16'd1;
              byte_idx_next    = 3'd0;
            end else begin
              // hold the low byte of a 16-bit sample
              low_hold_next = stg_byte;
              byte_idx_next = 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RIFF;
      byte_idx <= 3'd0;
      mismatch <= 1'b0;
      assembly <= 32'd0;
      skip     <= 32'd0;
    end else if (stg_adv) begin
      phase    <= phase_next;
      byte_idx <= byte_idx_next;
      mismatch <= mismatch_next;
      assembly <= assembly_next;
      skip     <= skip_next;
    end
  end

  // Field and sample registers: written only by a parsed byte
  always_ff @(posedge clk) begin
    if (stg_adv) begin
      bytes_left <= bytes_left_next;
      frame_len  <= frame_len_next;
      frame_pos  <= frame_pos_next;
      chan       <= chan_next;
      low_hold   <= low_hold_next;
      if (!skipping && field_last) begin
        case (cur_phase)
          PH_FSIZE:  riff_size       <= asm_acc;
          PH_LEN1:   fmt_length      <= asm_acc;
          PH_FORMAT: audio_format    <= asm_acc[15:0];
          PH_NCH:    chan_count      <= asm_acc[15:0];
          PH_RATE:   rate_hz         <= asm_acc;
          PH_BRATE:  byte_rate       <= asm_acc;
          PH_ALIGN:  block_align     <= asm_acc[15:0];
          PH_BPS:    bits_per_sample <= asm_acc[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  wavp_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (stg_adv && emit),
    .item   (res),
    .space  (buf_space),
    .result (result)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb
  import wavp_pkg::*;
();

  class wav_parse_scoreboard;
    localparam int SLOT_FILE_SIZE = 0;
    localparam int SLOT_FMT_LEN   = 1;
    localparam int SLOT_FORMAT    = 2;
    localparam int SLOT_NCH       = 3;
    localparam int SLOT_RATE      = 4;
    localparam int SLOT_BRATE     = 5;
    localparam int SLOT_ALIGN     = 6;
    localparam int SLOT_BPS       = 7;
    localparam int SLOT_DSIZE     = 8;

    phase_t       phase;
    logic [2:0]   byte_idx;
    logic         mismatch;
    logic [31:0]  gather;
    logic [31:0]  skip_left;
    logic [31:0]  hdr [9];
    logic [31:0]  bytes_left;
    logic [15:0]  chan_idx;
    logic [7:0]   low_hold;
    wavp_result_t due_results [$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase      = PH_RIFF;
      byte_idx   = '0;
      mismatch   = 1'b0;
      gather     = '0;
      skip_left  = '0;
      foreach (hdr[k]) hdr[k] = '0;
      bytes_left = '0;
      chan_idx   = '0;
      low_hold   = '0;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    // Tag bytes, then on a mismatch the 4-byte length of the chunk to skip
    function void tag_byte(logic [31:0] tag, phase_t nxt, logic [7:0] b);
      int k;
      k = byte_idx;
      if (k < 4) begin
        if (b != tag[8*(3-k) +: 8]) mismatch = 1'b1;
        if (k == 3) begin
          if (mismatch) begin
            byte_idx = 3'd4;
            gather   = '0;
          end else begin
            byte_idx = '0;
            phase    = nxt;
          end
        end else begin
          byte_idx = 3'(k + 1);
        end
      end else begin
        gather = gather | ({24'h0, b} << (8 * (k - 4)));
        if (k == 7) begin
          skip_left = gather;
          gather    = '0;
          byte_idx  = '0;
          mismatch  = 1'b0;
        end else begin
          byte_idx = 3'(k + 1);
        end
      end
    endfunction

    function void add_sample(logic [15:0] value);
      wavp_result_t r;
      r              = '0;
      r.kind         = KIND_SAMPLE;
      r.sample_value = value;
      r.channel      = chan_idx;
      due_results.insert(due_results.size(), r);
      if ({16'h0, chan_idx} + 32'd1 >= {16'h0, hdr[SLOT_NCH][15:0]}) chan_idx = '0;
      else chan_idx = chan_idx + 16'd1;
    endfunction

    function void add_header();
      wavp_result_t r;
      r                 = '0;
      r.kind            = KIND_HEADER;
      r.riff_size       = hdr[SLOT_FILE_SIZE];
      r.fmt_length      = hdr[SLOT_FMT_LEN];
      r.audio_format    = hdr[SLOT_FORMAT][15:0];
      r.chan_count      = hdr[SLOT_NCH][15:0];
      r.rate_hz         = hdr[SLOT_RATE];
      r.byte_rate       = hdr[SLOT_BRATE];
      r.block_align     = hdr[SLOT_ALIGN][15:0];
      r.bits_per_sample = hdr[SLOT_BPS][15:0];
      r.data_len        = hdr[SLOT_DSIZE];
      due_results.insert(due_results.size(), r);
    endfunction

    function void parse_byte(logic [7:0] b, logic sos);
      int          slot;
      int          nbytes;
      int          k;
      phase_t      nxt;
      logic [31:0] frame;
      if (sos) clear();
      if (skip_left != 0) begin
        skip_left = skip_left - 32'd1;
        return;
      end
      slot   = 0;
      nbytes = 0;
      nxt    = PH_DONE;
      case (phase)
        PH_RIFF: begin
          tag_byte(TAG_RIFF, PH_FSIZE, b);
          return;
        end
        PH_WAVE: begin
          tag_byte(TAG_WAVE, PH_FMT, b);
          return;
        end
        PH_FMT: begin
          tag_byte(TAG_FMT, PH_LEN1, b);
          return;
        end
        PH_DATA: begin
          tag_byte(TAG_DATA, PH_DSIZE, b);
          return;
        end
        PH_SAMPLES: begin
          if (bytes_left == 0) begin
            phase = PH_DONE;
            return;
          end
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == 0) phase = PH_DONE;
          if (hdr[SLOT_BPS][15:0] == BYTE_SAMPLE_BITS) begin
            add_sample({b, 8'h00});
            return;
          end
          if (byte_idx == 0) begin
            low_hold = b;
            byte_idx = 3'd1;
            return;
          end
          byte_idx = '0;
          add_sample({b, low_hold});
          return;
        end
        PH_FSIZE: begin
          slot = SLOT_FILE_SIZE; nbytes = 4; nxt = PH_WAVE;
        end
        PH_LEN1: begin
          slot = SLOT_FMT_LEN; nbytes = 4; nxt = PH_FORMAT;
        end
        PH_FORMAT: begin
          slot = SLOT_FORMAT; nbytes = 2; nxt = PH_NCH;
        end
        PH_NCH: begin
          slot = SLOT_NCH; nbytes = 2; nxt = PH_RATE;
        end
        PH_RATE: begin
          slot = SLOT_RATE; nbytes = 4; nxt = PH_BRATE;
        end
        PH_BRATE: begin
          slot = SLOT_BRATE; nbytes = 4; nxt = PH_ALIGN;
        end
        PH_ALIGN: begin
          slot = SLOT_ALIGN; nbytes = 2; nxt = PH_BPS;
        end
        PH_BPS: begin
          slot = SLOT_BPS; nbytes = 2; nxt = PH_DATA;
        end
        PH_DSIZE: begin
          slot = SLOT_DSIZE; nbytes = 4; nxt = PH_SAMPLES;
        end
        default: return;
      endcase

      k      = byte_idx[1:0];
      gather = gather | ({24'h0, b} << (8 * k));
      if (k + 1 < nbytes) begin
        byte_idx = 3'(k + 1);
        return;
      end
      hdr[slot] = gather;
      gather    = '0;
      byte_idx  = '0;
      phase     = nxt;

      if (phase == PH_DATA) begin
        // skip whatever the fmt chunk holds past the base fields
        if (hdr[SLOT_FMT_LEN] > FMT_BASE_LEN) skip_left = hdr[SLOT_FMT_LEN] - FMT_BASE_LEN;
      end else if (phase == PH_SAMPLES) begin
        frame = {16'h0, hdr[SLOT_NCH][15:0]} *
                ((hdr[SLOT_BPS][15:0] == BYTE_SAMPLE_BITS) ? 32'd1 : 32'd2);
        bytes_left = (frame == 0) ? 32'd0 : (hdr[SLOT_DSIZE] / frame) * frame;
        chan_idx   = '0;
        if (bytes_left == 0) phase = PH_DONE;
        add_header();
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(wavp_result_t got);
      wavp_result_t want;
      if (due_results.size() == 0) begin
        $error("result: none outstanding, actual kind %0d", got.kind);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("sample_value", want.sample_value, got.sample_value);
      check_field("channel", want.channel, got.channel);
      check_field("riff_size", want.riff_size, got.riff_size);
      check_field("fmt_length", want.fmt_length, got.fmt_length);
      check_field("audio_format", want.audio_format, got.audio_format);
      check_field("chan_count", want.chan_count, got.chan_count);
      check_field("rate_hz", want.rate_hz, got.rate_hz);
      check_field("byte_rate", want.byte_rate, got.byte_rate);
      check_field("block_align", want.block_align, got.block_align);
      check_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
      check_field("data_len", want.data_len, got.data_len);
    endfunction
  endclass

  // Quiet-cycle limit: covers the long result hold-off plus random idling.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BYTES = 750;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic       sos;
    logic [7:0] b;
  } stream_byte_t;

  logic clk;
  logic rst;

  wavp_in_if  stream_if ();
  wavp_out_if result_if ();

  wav_header_and_sample_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  wav_parse_scoreboard sb = new();

  stream_byte_t file_q [$];
  int           src_idle_pct = 13;
  int           snk_idle_pct = 60;
  bit           hold_off_pending = 1'b0;
  int           quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // File assembly: the helpers build the file in file_q
  // ---------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    file_q.insert(file_q.size(), {1'b0, b});
  endfunction

  // Tags are stored first character in the top byte
  function automatic void push_tag(logic [31:0] tag);
    for (int k = 3; k >= 0; k--) push_byte(tag[8*k +: 8]);
  endfunction

  // Little-endian field of n bytes
  function automatic void push_le(logic [31:0] value, int n);
    for (int k = 0; k < n; k++) push_byte(value[8*k +: 8]);
  endfunction

  // Unknown chunk: random tag, length, then that many filler bytes
  function automatic void push_junk(int len);
    push_tag($urandom);
    push_le(len, 4);
    repeat (len) push_byte(8'($urandom));
  endfunction

  // Sample bytes lean on the extremes now and then
  function automatic logic [7:0] pick_data_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return 8'h00;
    if (pick < 6) return 8'hFF;
    if (pick < 8) return 8'h80;
    if (pick < 10) return 8'h7F;
    return 8'($urandom);
  endfunction

  // Build one WAV file. junk_mask bit 0..3 drops an unknown chunk in front
  // of the RIFF, WAVE, fmt and data tags; a negative junk_len picks each
  // chunk length at random.
  function automatic void build_wav(logic sos_first, logic [15:0] nch, logic [15:0] bps,
                                    logic [31:0] fmt_len, logic [31:0] dsize, int n_data,
                                    logic [3:0] junk_mask, int junk_len);
    file_q.delete();
    if (junk_mask[0]) push_junk(junk_len < 0 ? $urandom_range(0, 6) : junk_len);
    push_tag(TAG_RIFF);
    push_le($urandom, 4);
    if (junk_mask[1]) push_junk(junk_len < 0 ? $urandom_range(0, 6) : junk_len);
    push_tag(TAG_WAVE);
    if (junk_mask[2]) push_junk(junk_len < 0 ? $urandom_range(0, 6) : junk_len);
    push_tag(TAG_FMT);
    push_le(fmt_len, 4);
    push_le($urandom, 2);
    push_le(nch, 2);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le($urandom, 2);
    push_le(bps, 2);
    // a long fmt chunk carries extra bytes after the base fields
    if (fmt_len > FMT_BASE_LEN) repeat (fmt_len - FMT_BASE_LEN) push_byte(8'($urandom));
    if (junk_mask[3]) push_junk(junk_len < 0 ? $urandom_range(0, 6) : junk_len);
    push_tag(TAG_DATA);
    push_le(dsize, 4);
    repeat (n_data) push_byte(pick_data_byte());
    file_q[0].sos = sos_first;
  endfunction

  // Mostly well-formed files with random content; some corrupted or noise.
  function automatic void build_random_wav();
    logic [15:0] nch;
    logic [15:0] bps;
    logic [31:0] fmt_len;
    logic [31:0] dsize;
    int          n_data;
    int          pick;
    pick = $urandom_range(99);
    nch = (pick < 8) ? 16'd0 : (pick < 14) ? 16'($urandom) : 16'($urandom_range(1, 4));
    pick = $urandom_range(99);
    bps = (pick < 45) ? BYTE_SAMPLE_BITS : (pick < 85) ? 16'd16 : 16'($urandom);
    pick = $urandom_range(99);
    fmt_len = (pick < 70) ? FMT_BASE_LEN :
              (pick < 85) ? 32'($urandom_range(0, 15)) : 32'($urandom_range(17, 24));
    if ($urandom_range(99) < 8) begin
      // huge data size: the file simply ends early
      dsize  = $urandom;
      n_data = $urandom_range(0, 48);
    end else begin
      dsize  = $urandom_range(0, 48);
      n_data = dsize + $urandom_range(0, 3);
    end
    build_wav($urandom_range(99) < 95, nch, bps, fmt_len, dsize, n_data,
              ($urandom_range(99) < 30) ? 4'($urandom_range(1, 15)) : 4'd0, -1);
    // corrupt a byte now and then to break the header
    if ($urandom_range(99) < 6) file_q[$urandom_range(file_q.size() - 1)].b = 8'($urandom);
    // stray bytes in front of the file
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 8)) file_q.push_front({1'($urandom), 8'($urandom)});
    end
  endfunction

  // ---------------------------------------------------------------
  // Stream side: one item per call, random idle cycles first
  // ---------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sos);
    while ($urandom_range(99) < src_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid           <= 1'b1;
    stream_if.data_byte       <= b;
    stream_if.start_of_stream <= sos;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    sb.parse_byte(b, sos);
  endtask

  task automatic send_file(output int count);
    count = file_q.size();
    foreach (file_q[k]) send_byte(file_q[k].b, file_q[k].sos);
    file_q.delete();
  endtask

  // ---------------------------------------------------------------
  // Result side: check accepted items, random ready, one long hold-off
  // ---------------------------------------------------------------
  initial begin
    wavp_result_t got;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        got.kind            = result_if.kind;
        got.sample_value    = result_if.sample_value;
        got.channel         = result_if.channel;
        got.riff_size       = result_if.riff_size;
        got.fmt_length      = result_if.fmt_length;
        got.audio_format    = result_if.audio_format;
        got.chan_count      = result_if.chan_count;
        got.rate_hz         = result_if.rate_hz;
        got.byte_rate       = result_if.byte_rate;
        got.block_align     = result_if.block_align;
        got.bits_per_sample = result_if.bits_per_sample;
        got.data_len        = result_if.data_len;
        sb.check_result(got);
      end
      if (hold_off_pending) begin
        // hold ready low so the output buffer fills and the stream stalls
        hold_off_pending = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------
  // Watchdog: end the run after too many cycles with no handshake
  // ---------------------------------------------------------------
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("wav_header_and_sample_parser verification failed");
    $finish;
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  initial begin
    int sent;
    int n;
    bit pressure_done;
    sent          = 0;
    pressure_done = 1'b0;
    rst                       = 1'b1;
    stream_if.valid           = 1'b0;
    stream_if.data_byte       = 8'h00;
    stream_if.start_of_stream = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed files.
    // Stray extreme bytes, then a restart on a byte that is not a tag.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Three channels of byte samples: zero-length chunks before WAVE and fmt,
    // a long fmt chunk, channel wrap, a partial frame and bytes after the data.
    build_wav(1'b1, 16'd3, BYTE_SAMPLE_BITS, 32'd18, 32'd10, 12, 4'b0110, 0);
    send_file(n);
    // Zero channels with a short fmt chunk: header only, no samples.
    build_wav(1'b1, 16'd0, 16'd16, 32'd12, 32'd8, 8, 4'b0000, 0);
    send_file(n);
    // Odd sample width read as 16 bits, stereo, odd data size; skipped chunks
    // before RIFF and data.
    build_wav(1'b1, 16'd2, 16'd24, FMT_BASE_LEN, 32'd7, 7, 4'b1001, 3);
    send_file(n);

    // Random files, by thirds: idling mostly on the result side, then mostly on the stream side, then none.
    while (sent < RANDOM_BYTES) begin
      if (sent < RANDOM_BYTES / 3) begin
        src_idle_pct = 13;
        snk_idle_pct = 60;
      end else if (sent < 2 * RANDOM_BYTES / 3) begin
        src_idle_pct = 60;
        snk_idle_pct = 13;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        if (!pressure_done) begin
          // mono byte samples streamed into a stalled result side
          pressure_done    = 1'b1;
          hold_off_pending = 1'b1;
          build_wav(1'b1, 16'd1, BYTE_SAMPLE_BITS, FMT_BASE_LEN, 32'd40, 40, 4'b0000, 0);
          send_file(n);
          sent += n;
        end
      end
      build_random_wav();
      send_file(n);
      sent += n;
    end
    stream_if.valid <= 1'b0;

    // Drain: wait for every outstanding result, then watch for strays.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("wav_header_and_sample_parser verification clean");
    end else begin
      $display("wav_header_and_sample_parser verification failed");
    end
    $finish;
  end
endmodule

@@ wav_header_and_sample_parser.f @@
rtl/core/wavp_pkg.sv
rtl/core/wavp_if.sv
rtl/core/wavp_out_buf.sv
rtl/core/wav_header_and_sample_parser.sv
verif/tb.sv
